// ===== src/wrch_pkg.sv =====
// Shared types and constants for the wind rose cell histogram.
package wrch_pkg;
   localparam int CNT_W = 24;
   localparam int SUM_W = 32;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic signed [11:0] COMP_LIMIT = 12'sd1600;
   localparam logic [1:0] REG_GALE = 2'd0;
   localparam logic [1:0] REG_CALM = 2'd1;
   localparam logic [1:0] REG_BINW = 2'd2;
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ = 1'b1;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SUM_W-1:0] sum_type;
endpackage

// ===== src/wind_rose_cell_histogram.sv =====
// Top level of the wind rose cell histogram: sample accumulation and counter reads.
//
//  channel | ports            | direction | beat
//  req     | req_valid/stall  | in        | one sample or read command
//  rsp     | rsp_valid/stall  | out       | one result per request
//  csr     | APB csr_*        | in        | threshold and bin width writes
//
// After reset a clearing pass sweeps all counter memories, one cell a cycle;
// req_stall stays high meanwhile.
// The result register is loaded after a read is accepted once the cell row is
// read, after a dropped sample once it is checked, and after a kept sample once
// it has taken 12 root steps, 1 to 4 bin divide steps (the shared subtractor
// serves both), then a read and a write of each cell memory.
// The result sits in an output register; the block stalls its input until
// that register is taken and through the cycle after.
module wind_rose_cell_histogram #(
   parameter int OUT_ROWS = 16,
   parameter int OUT_COLS = 32,
   parameter int SECTORS = 8,
   parameter int SPEED_BINS = 4,
   parameter int FOLD_RATIO = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic        req_sample_present,
   input  logic [5:0]  req_grid_row,
   input  logic [6:0]  req_grid_col,
   input  logic signed [11:0] req_east_speed,
   input  logic signed [11:0] req_north_speed,
   input  logic [5:0]  req_counter_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic        rsp_sample_counted,
   output logic [2:0]  rsp_sector,
   output logic [11:0] rsp_speed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int CELLS = OUT_ROWS * OUT_COLS;
   localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int BW = (SPEED_BINS > 1) ? $clog2(SPEED_BINS) : 1;
   localparam int SEL_SEC = 3;
   localparam int SEL_SUM = 3 + SECTORS;
   localparam int SEL_BIN = 3 + 2 * SECTORS;
   localparam int SEL_MAX = 3 + 2 * SECTORS + SPEED_BINS * SECTORS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_CHECK = 4'd2;
   localparam logic [3:0] ST_ROOT  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_RD    = 4'd5;
   localparam logic [3:0] ST_WB    = 4'd6;
   localparam logic [3:0] ST_READ  = 4'd7;
   localparam logic [3:0] ST_READ2 = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   // configuration
   logic [11:0] gale_ff, calm_ff;
   logic [9:0]  binw_ff;
   logic        wr_en;
   assign pready = 1'b1;
   assign wr_en = psel & penable & pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         gale_ff <= 12'd544;
         calm_ff <= 12'd48;
         binw_ff <= 10'd160;
      end else if (wr_en) begin
         case (paddr[3:2])
            wrch_pkg::REG_GALE: gale_ff <= pwdata[11:0];
            wrch_pkg::REG_CALM: calm_ff <= pwdata[11:0];
            wrch_pkg::REG_BINW: binw_ff <= pwdata[9:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (paddr[3:2])
         wrch_pkg::REG_GALE: prdata = {20'd0, gale_ff};
         wrch_pkg::REG_CALM: prdata = {20'd0, calm_ff};
         wrch_pkg::REG_BINW: prdata = {22'd0, binw_ff};
         default: prdata = 32'd0;
      endcase
   end

   // cell memories, one row per cell
   wrch_pkg::cnt_type calm_mem  [CELLS];
   wrch_pkg::cnt_type gale_mem  [CELLS];
   wrch_pkg::cnt_type total_mem [CELLS];
   logic [SECTORS*24-1:0] sec_mem [CELLS];
   logic [SECTORS*32-1:0] sum_mem [CELLS];
   logic [SPEED_BINS*SECTORS*24-1:0] bin_mem [CELLS];

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] cell_ff;
   logic [CW:0] clr_ff;
   logic [5:0]  sel_ff;
   logic signed [11:0] east_ff, north_ff;
   logic        pres_ff;
   logic [23:0] rem_ff;      // root remainder / divide remainder
   logic [11:0] root_ff;
   logic [3:0]  step_ff;
   logic [BW-1:0] bin_ff;
   logic [2:0]  sec_ff;
   wrch_pkg::cnt_type largest_ff;
   wrch_pkg::cnt_type rd_calm_ff, rd_gale_ff, rd_total_ff;
   logic [SECTORS*24-1:0] rd_sec_ff;
   logic [SECTORS*32-1:0] rd_sum_ff;
   logic [SPEED_BINS*SECTORS*24-1:0] rd_bin_ff;
   logic        out_valid_ff;
   logic [31:0] out_value_ff;
   logic        out_counted_ff;
   logic [2:0]  out_sec_ff;
   logic [11:0] out_speed_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_sample_counted = out_counted_ff;
   assign rsp_sector = out_sec_ff;
   assign rsp_speed = out_speed_ff;

   // folded cell index
   logic [CW-1:0] req_cell;
   always_comb begin
      logic [31:0] r, c;
      r = 32'(req_grid_row / FOLD_RATIO) % 32'(OUT_ROWS);
      c = 32'(req_grid_col / FOLD_RATIO) % 32'(OUT_COLS);
      req_cell = CW'(r * 32'(OUT_COLS) + c);
   end

   // sector from source direction x = -north, y = -east
   logic [2:0] sector_w;
   always_comb begin
      logic signed [12:0] x, y;
      logic [11:0] ax, ay;
      logic [25:0] s2, tx, ty;
      x = -13'(north_ff);
      y = -13'(east_ff);
      ax = 12'(x < 0 ? -x : x);
      ay = 12'(y < 0 ? -y : y);
      s2 = 26'(({1'b0, ax} + {1'b0, ay}) * ({1'b0, ax} + {1'b0, ay}));
      tx = 26'(ax) * 26'(ax) * 26'd2;
      ty = 26'(ay) * 26'(ay) * 26'd2;
      if (ax == 0 && ay == 0) sector_w = 3'd0;
      else if (s2 < tx) sector_w = (x > 0) ? 3'd0 : 3'd4;
      else if (s2 < ty) sector_w = (y > 0) ? 3'd2 : 3'd6;
      else if (x > 0) sector_w = (y > 0) ? 3'd1 : 3'd7;
      else sector_w = (y > 0) ? 3'd3 : 3'd5;
   end

   // shared subtract unit: root step or divide step
   logic [25:0] sub_a, sub_b, sub_d;
   logic        sub_ok;
   logic [23:0] sq_sum;
   logic [9:0]  wdiv;
   assign sq_sum = 24'($unsigned(24'(east_ff) * 24'(east_ff))
                      + $unsigned(24'(north_ff) * 24'(north_ff)));
   assign wdiv = (binw_ff == 10'd0) ? 10'd1 : binw_ff;
   always_comb begin
      if (state_ff == ST_ROOT) begin
         sub_a = {2'd0, rem_ff[21:0], sq_sum[5'(2*step_ff+1) -: 2]};
         sub_b = {12'd0, root_ff, 2'b01};
      end else begin
         sub_a = {2'd0, rem_ff};
         sub_b = {16'd0, wdiv};
      end
      sub_ok = sub_a >= sub_b;
      sub_d = sub_a - sub_b;
   end

   logic speed_ok;
   assign speed_ok = pres_ff && east_ff <= wrch_pkg::COMP_LIMIT
      && east_ff >= -wrch_pkg::COMP_LIMIT && north_ff <= wrch_pkg::COMP_LIMIT
      && north_ff >= -wrch_pkg::COMP_LIMIT;

   wrch_pkg::cnt_type new_total;
   assign new_total = (rd_total_ff == wrch_pkg::CNT_MAX) ? rd_total_ff : rd_total_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = (req_opcode == wrch_pkg::OP_READ) ? ST_READ : ST_CHECK;
         ST_CLEAR: if (clr_ff == (CW+1)'(CELLS - 1)) state_in = ST_OUT;
         ST_CHECK: state_in = speed_ok ? ST_ROOT : ST_OUT;
         ST_ROOT:  if (step_ff == 4'd0) state_in = ST_DIV;
         ST_DIV:   if (!sub_ok || bin_ff == BW'(SPEED_BINS - 1)) state_in = ST_RD;
         ST_RD:    state_in = ST_WB;
         ST_WB:    state_in = ST_OUT;
         ST_READ:  state_in = ST_READ2;
         ST_READ2: state_in = ST_OUT;
         ST_OUT:   if (!out_valid_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         largest_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: if (req_valid) begin
               sel_ff <= req_counter_select;
               east_ff <= req_east_speed; north_ff <= req_north_speed;
               pres_ff <= req_sample_present; cell_ff <= req_cell;
            end
            ST_CHECK: begin
               rem_ff <= '0; root_ff <= '0; step_ff <= 4'd11; bin_ff <= '0;
               out_value_ff <= '0; out_counted_ff <= 1'b0;
               out_sec_ff <= '0; out_speed_ff <= '0;
               sec_ff <= sector_w;
               if (!speed_ok) out_valid_ff <= 1'b1;
            end
            ST_ROOT: begin
               // restoring root: two bits of the radicand a step
               logic [11:0] r;
               logic [23:0] rm;
               r = sub_ok ? {root_ff[10:0], 1'b1} : {root_ff[10:0], 1'b0};
               rm = sub_ok ? sub_d[23:0] : sub_a[23:0];
               step_ff <= step_ff - 1'b1;
               if (step_ff == 4'd0) begin
                  // round to nearest: bump when remainder exceeds the floor root
                  r = (rm > {12'd0, r}) ? r + 1'b1 : r;
                  root_ff <= r;
                  rem_ff <= {12'd0, r};
               end else begin
                  root_ff <= r;
                  rem_ff <= rm;
               end
            end
            ST_DIV: if (sub_ok && bin_ff != BW'(SPEED_BINS - 1)) begin
               rem_ff <= sub_d[23:0]; bin_ff <= bin_ff + 1'b1;
            end
            ST_RD, ST_READ: begin
               rd_calm_ff <= calm_mem[cell_ff]; rd_gale_ff <= gale_mem[cell_ff];
               rd_total_ff <= total_mem[cell_ff]; rd_sec_ff <= sec_mem[cell_ff];
               rd_sum_ff <= sum_mem[cell_ff]; rd_bin_ff <= bin_mem[cell_ff];
            end
            ST_WB: begin
               if (largest_ff < new_total) largest_ff <= new_total;
               out_valid_ff <= 1'b1; out_counted_ff <= 1'b1;
               out_sec_ff <= sec_ff; out_speed_ff <= root_ff;
            end
            ST_READ2: begin
               out_valid_ff <= 1'b1; out_counted_ff <= 1'b0;
               out_sec_ff <= '0; out_speed_ff <= '0;
               if (sel_ff == 6'd0) out_value_ff <= 32'(rd_calm_ff);
               else if (sel_ff == 6'd1) out_value_ff <= 32'(rd_gale_ff);
               else if (sel_ff == 6'd2) out_value_ff <= 32'(rd_total_ff);
               else if (32'(sel_ff) < SEL_SUM)
                  out_value_ff <= 32'(rd_sec_ff[(32'(sel_ff) - SEL_SEC)*24 +: 24]);
               else if (32'(sel_ff) < SEL_BIN)
                  out_value_ff <= rd_sum_ff[(32'(sel_ff) - SEL_SUM)*32 +: 32];
               else if (32'(sel_ff) < SEL_MAX)
                  out_value_ff <= 32'(rd_bin_ff[(32'(sel_ff) - SEL_BIN)*24 +: 24]);
               else if (32'(sel_ff) == SEL_MAX) out_value_ff <= 32'(largest_ff);
               else out_value_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // memory writes: clearing pass and sample write-back
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         calm_mem[clr_ff[CW-1:0]] <= '0; gale_mem[clr_ff[CW-1:0]] <= '0;
         total_mem[clr_ff[CW-1:0]] <= '0; sec_mem[clr_ff[CW-1:0]] <= '0;
         sum_mem[clr_ff[CW-1:0]] <= '0; bin_mem[clr_ff[CW-1:0]] <= '0;
      end else if (state_ff == ST_WB) begin
         logic [SECTORS*24-1:0] s;
         logic [SECTORS*32-1:0] m;
         logic [SPEED_BINS*SECTORS*24-1:0] b;
         logic [23:0] c;
         logic [32:0] su;
         s = rd_sec_ff; m = rd_sum_ff; b = rd_bin_ff;
         if (root_ff >= gale_ff)
            gale_mem[cell_ff] <= (rd_gale_ff == wrch_pkg::CNT_MAX) ? rd_gale_ff
                                 : rd_gale_ff + 1'b1;
         else if (root_ff <= calm_ff)
            calm_mem[cell_ff] <= (rd_calm_ff == wrch_pkg::CNT_MAX) ? rd_calm_ff
                                 : rd_calm_ff + 1'b1;
         total_mem[cell_ff] <= new_total;
         c = s[32'(sec_ff)*24 +: 24];
         s[32'(sec_ff)*24 +: 24] = (c == wrch_pkg::CNT_MAX) ? c : c + 1'b1;
         su = {1'b0, m[32'(sec_ff)*32 +: 32]} + 33'(root_ff);
         m[32'(sec_ff)*32 +: 32] = su[32] ? wrch_pkg::SUM_MAX : su[31:0];
         c = b[(32'(bin_ff)*SECTORS + 32'(sec_ff))*24 +: 24];
         b[(32'(bin_ff)*SECTORS + 32'(sec_ff))*24 +: 24] =
            (c == wrch_pkg::CNT_MAX) ? c : c + 1'b1;
         sec_mem[cell_ff] <= s; sum_mem[cell_ff] <= m; bin_mem[cell_ff] <= b;
      end
   end
endmodule

// ===== test/wind_rose_cell_histogram_test.sv =====
// Self-checking testbench for the wind rose cell histogram.
`timescale 1ns / 100ps

module wind_rose_cell_histogram_test;
   localparam int ROWS = 16;
   localparam int COLS = 32;
   localparam int NSEC = 8;
   localparam int NBIN = 4;
   localparam int NCELL = ROWS * COLS;
   localparam int SEL_SUMS = 3 + NSEC;
   localparam int SEL_BINS = 3 + 2 * NSEC;
   localparam int SEL_LARGEST = SEL_BINS + NBIN * NSEC;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic              opcode;
      logic              present;
      logic [5:0]        row;
      logic [6:0]        col;
      logic signed [11:0] east;
      logic signed [11:0] north;
      logic [5:0]        sel;
   } wind_item_type;

   typedef struct packed {
      logic [31:0] value;
      logic        counted;
      logic [2:0]  sector;
      logic [11:0] speed;
   } wind_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   wind_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_read_value;
   logic rsp_sample_counted;
   logic [2:0] rsp_sector;
   logic [11:0] rsp_speed;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   wind_rose_cell_histogram DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_item.opcode), .req_sample_present(req_item.present),
      .req_grid_row(req_item.row), .req_grid_col(req_item.col),
      .req_east_speed(req_item.east), .req_north_speed(req_item.north),
      .req_counter_select(req_item.sel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value), .rsp_sample_counted(rsp_sample_counted),
      .rsp_sector(rsp_sector), .rsp_speed(rsp_speed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the block's histogram store and registers
   logic [11:0] gale_thr, calm_thr;
   logic [9:0]  bin_width;
   wrch_pkg::cnt_type calm_cnt [NCELL];
   wrch_pkg::cnt_type gale_cnt [NCELL];
   wrch_pkg::cnt_type total_cnt [NCELL];
   wrch_pkg::cnt_type sector_cnt [NCELL*NSEC];
   wrch_pkg::sum_type speed_sum [NCELL*NSEC];
   wrch_pkg::cnt_type bin_cnt [NCELL*NBIN*NSEC];
   wrch_pkg::cnt_type largest;

   wind_item_type   pending_items[$];
   wind_result_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   bit stim_done = 1'b0;

   function automatic wrch_pkg::cnt_type bump(wrch_pkg::cnt_type c);
      return (c == wrch_pkg::CNT_MAX) ? c : c + 1'b1;
   endfunction

   // Floor root by bit pairs, then round up when the remainder exceeds the root
   function automatic logic [11:0] wind_speed(logic [31:0] sq);
      logic [31:0] r, b, s;
      r = 0; s = sq; b = 32'h4000_0000;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s > r) r = r + 1;
      return r[11:0];
   endfunction

   // Source sector: x points north of the source bearing, y east
   function automatic logic [2:0] source_sector(int x, int y);
      longint ax, ay, s2;
      ax = longint'((x < 0) ? -x : x);
      ay = longint'((y < 0) ? -y : y);
      s2 = (ax + ay) * (ax + ay);
      if (ax == 0 && ay == 0) return 3'd0;
      if (s2 < 2 * ax * ax) return (x > 0) ? 3'd0 : 3'd4;
      if (s2 < 2 * ay * ay) return (y > 0) ? 3'd2 : 3'd6;
      if (x > 0) return (y > 0) ? 3'd1 : 3'd7;
      return (y > 0) ? 3'd3 : 3'd5;
   endfunction

   function automatic wind_result_type predict_histogram(wind_item_type it);
      wind_result_type res;
      int cell_idx, e, n, sel, idx, bin, w;
      logic [2:0] sec;
      logic [11:0] spd;
      res = '0;
      cell_idx = ((int'(it.row) / 2) % ROWS) * COLS + ((int'(it.col) / 2) % COLS);
      if (it.opcode == wrch_pkg::OP_READ) begin
         sel = int'(it.sel);
         if (sel == 0) res.value = 32'(calm_cnt[cell_idx]);
         else if (sel == 1) res.value = 32'(gale_cnt[cell_idx]);
         else if (sel == 2) res.value = 32'(total_cnt[cell_idx]);
         else if (sel < SEL_SUMS) res.value = 32'(sector_cnt[cell_idx*NSEC + sel - 3]);
         else if (sel < SEL_BINS) res.value = speed_sum[cell_idx*NSEC + sel - SEL_SUMS];
         else if (sel < SEL_LARGEST)
            res.value = 32'(bin_cnt[cell_idx*NBIN*NSEC + sel - SEL_BINS]);
         else if (sel == SEL_LARGEST) res.value = 32'(largest);
         return res;
      end
      if (!it.present) return res;
      e = int'(it.east);
      n = int'(it.north);
      if (e > 1600 || e < -1600 || n > 1600 || n < -1600) return res;
      sec = source_sector(-n, -e);
      spd = wind_speed(32'(e * e + n * n));
      if (spd >= gale_thr) gale_cnt[cell_idx] = bump(gale_cnt[cell_idx]);
      else if (spd <= calm_thr) calm_cnt[cell_idx] = bump(calm_cnt[cell_idx]);
      total_cnt[cell_idx] = bump(total_cnt[cell_idx]);
      if (largest < total_cnt[cell_idx]) largest = total_cnt[cell_idx];
      idx = cell_idx * NSEC + int'(sec);
      sector_cnt[idx] = bump(sector_cnt[idx]);
      speed_sum[idx] = (speed_sum[idx] > wrch_pkg::SUM_MAX - 32'(spd)) ? wrch_pkg::SUM_MAX
                       : speed_sum[idx] + 32'(spd);
      w = (bin_width == 0) ? 1 : int'(bin_width);
      bin = int'(spd) / w;
      if (bin >= NBIN) bin = NBIN - 1;
      idx = (cell_idx * NBIN + bin) * NSEC + int'(sec);
      bin_cnt[idx] = bump(bin_cnt[idx]);
      res.counted = 1'b1;
      res.sector = sec;
      res.speed = spd;
      return res;
   endfunction

   // Driver: present queued beats with a random gap before each
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         expected_results.push_back(predict_histogram(req_item));
         send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         if (send_gap == 0 && pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation
   int hold_cnt = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result beat value=%0h", rsp_read_value);
            end else begin
               wind_result_type exp_r;
               exp_r = expected_results.pop_front();
               if (exp_r.value !== rsp_read_value || exp_r.counted !== rsp_sample_counted ||
                   exp_r.sector !== rsp_sector || exp_r.speed !== rsp_speed) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp val=%0h cnt=%0b sec=%0d spd=%0d, ",
                               "got val=%0h cnt=%0b sec=%0d spd=%0d"},
                              exp_r.value, exp_r.counted, exp_r.sector, exp_r.speed,
                              rsp_read_value, rsp_sample_counted, rsp_sector, rsp_speed);
               end
            end
            hold_cnt = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
            rsp_stall <= (hold_cnt > 0);
         end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            rsp_stall <= (hold_cnt > 0);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {index, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         wrch_pkg::REG_GALE: gale_thr = value[11:0];
         wrch_pkg::REG_CALM: calm_thr = value[11:0];
         default: bin_width = value[9:0];
      endcase
   endtask

   // Hold until every beat is sent and answered, then let the block settle
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic wind_item_type wind_sample(int e, int n, int r, int c);
      wind_item_type it;
      it = '0;
      it.opcode = wrch_pkg::OP_SAMPLE; it.present = 1'b1;
      it.row = 6'(r); it.col = 7'(c); it.east = 12'(e); it.north = 12'(n);
      it.sel = 6'($urandom_range(0, 63));
      return it;
   endfunction

   function automatic wind_item_type counter_read(int r, int c, int sel);
      wind_item_type it;
      it = '0;
      it.opcode = wrch_pkg::OP_READ; it.present = 1'($urandom_range(0, 1));
      it.row = 6'(r); it.col = 7'(c); it.sel = 6'(sel);
      it.east = 12'($urandom); it.north = 12'($urandom);
      return it;
   endfunction

   // Random item: a counter read or a sample, mostly in range, focused on few cells so counters grow
   function automatic wind_item_type random_item();
      wind_item_type it;
      int k;
      k = $urandom_range(0, 99);
      if (k < 25) begin
         it = counter_read($urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom_range(0, 10) == 0 ? $urandom_range(0, 63)
                                                      : $urandom_range(0, SEL_LARGEST));
         if ($urandom_range(0, 5) == 0) begin
            it.row = 6'($urandom); it.col = 7'($urandom);
         end
      end else begin
         it = wind_sample($urandom_range(0, 3200) - 1600, $urandom_range(0, 3200) - 1600,
                          $urandom_range(0, 7), $urandom_range(0, 7));
         if (k < 35) begin
            it.east = 12'($urandom); it.north = 12'($urandom);
         end else if (k < 40) begin
            it.present = 1'b0;
         end else if (k < 50) begin
            it.row = 6'($urandom); it.col = 7'($urandom);
         end else if (k < 60) begin
            it.east = 12'($urandom_range(0, 80) - 40);
            it.north = 12'($urandom_range(0, 80) - 40);
         end
      end
      return it;
   endfunction

   int s;
   initial begin
      gale_thr = 544; calm_thr = 48; bin_width = 160; largest = '0;
      foreach (calm_cnt[i]) begin
         calm_cnt[i] = '0; gale_cnt[i] = '0; total_cnt[i] = '0;
      end
      foreach (sector_cnt[i]) begin
         sector_cnt[i] = '0; speed_sum[i] = '0;
      end
      foreach (bin_cnt[i]) bin_cnt[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, compass points, drops, folding, odd selects
      pending_items.push_back(wind_sample(0, 0, 0, 0));
      pending_items.push_back(wind_sample(0, 1600, 0, 0));
      pending_items.push_back(wind_sample(1600, 1600, 0, 0));
      pending_items.push_back(wind_sample(1600, 0, 1, 1));
      pending_items.push_back(wind_sample(-1600, -1600, 63, 127));
      pending_items.push_back(wind_sample(-1600, 0, 32, 64));
      pending_items.push_back(wind_sample(0, -1600, 0, 0));
      pending_items.push_back(wind_sample(-1600, 1600, 0, 0));
      pending_items.push_back(wind_sample(1600, -1600, 0, 0));
      pending_items.push_back(wind_sample(1601, 0, 0, 0));
      pending_items.push_back(wind_sample(0, -1601, 0, 0));
      pending_items.push_back(wind_sample(-2048, 2047, 0, 0));
      pending_items.push_back(wind_sample(30, -20, 2, 3));
      begin
         wind_item_type it;
         it = wind_sample(100, 100, 0, 0);
         it.present = 1'b0;
         pending_items.push_back(it);
      end
      for (s = 0; s <= SEL_LARGEST + 1; s += 5) pending_items.push_back(counter_read(0, 0, s));
      pending_items.push_back(counter_read(0, 1, SEL_LARGEST));
      pending_items.push_back(counter_read(63, 127, 63));
      drain();

      csr_write(wrch_pkg::REG_GALE, 32'hFFF);
      csr_write(wrch_pkg::REG_CALM, 32'hFFF);
      csr_write(wrch_pkg::REG_BINW, 32'd0);
      for (s = 0; s < 150; s++) pending_items.push_back(random_item());
      drain();

      csr_write(wrch_pkg::REG_GALE, 32'd0);
      csr_write(wrch_pkg::REG_CALM, 32'd0);
      csr_write(wrch_pkg::REG_BINW, 32'h3FF);
      for (s = 0; s < 150; s++) pending_items.push_back(random_item());
      drain();

      csr_write(wrch_pkg::REG_GALE, $urandom_range(200, 1500));
      csr_write(wrch_pkg::REG_CALM, $urandom_range(0, 300));
      csr_write(wrch_pkg::REG_BINW, $urandom_range(1, 600));
      for (s = 0; s < 200; s++) pending_items.push_back(random_item());
      for (s = 0; s <= SEL_LARGEST; s++) pending_items.push_back(counter_read(0, 0, s));
      drain();

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
